>>> rtl/core/dpd_pkg.sv
// Shared types, character codes and helpers for the debug packet deframer.
package dpd_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam logic [11:0] MAX_PAYLOAD_RESET = 12'd399;
    localparam logic [11:0] HELD_DEPTH        = 12'd3;

    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd0;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_HIGH    = 4'b0100,
        PH_LOW     = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BAD      = 3'd2,
        KIND_RESTART  = 3'd3,
        KIND_OVERFLOW = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] ack_char;
        logic       seq_valid;
        logic [7:0] seq_first;
        logic [7:0] seq_second;
        logic       last;
    } t_result;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        return v;
    endfunction

    function automatic t_result simple_result(input t_kind kind, input logic [7:0] data);
        t_result r;
        r = '0;
        r.kind = kind;
        r.data = data;
        return r;
    endfunction

endpackage

>>> rtl/core/debug_packet_deframer_core.sv
// Debug packet deframer: frames dollar/hash packets, checks the sum, strips sequence IDs.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------
//  rx in     | i_rx_valid / o_rx_stall    | i_rx_byte
//  result out| o_res_valid / i_res_stall  | o_kind o_data o_ack_char o_seq_* o_last
//  config    | psel penable pwrite pready | paddr pwdata prdata (max_payload @ 0x0)
//
//  A byte is registered, then decoded into a registered bundle of zero to three results.
//  Throughput is one byte per cycle if no byte gives more than one result and the
//  result port does not stall; otherwise the result port sets the rate.
//  Synchronous active-low reset clears phase, sum, count, flags and max_payload (399).
//  The input is stalled only while a registered byte waits for the bundle to drain.
module debug_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [7:0]  o_ack_char,
    output logic        o_seq_valid,
    output logic [7:0]  o_seq_first,
    output logic [7:0]  o_seq_second,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dpd_pkg::t_phase  r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [11:0]      r_count, n_count;
    logic [7:0]       r_held [3];
    logic [7:0]       n_held [3];
    logic [7:0]       r_high, n_high;
    logic             r_seq, n_seq;
    logic [11:0]      r_max;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    dpd_pkg::t_result r_bundle [3];
    dpd_pkg::t_result n_bundle [3];
    logic [1:0]       r_cnt, n_num;
    logic [1:0]       r_idx;

    logic             process;
    logic             out_take;
    logic             out_final;
    logic [12:0]      cnt_next;
    logic [7:0]       sent;
    dpd_pkg::t_result cur;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {20'd0, r_max} : 32'd0;

    assign out_take  = o_res_valid && !i_res_stall;
    assign out_final = r_idx == (r_cnt - 2'd1);
    assign process   = r_in_valid && (r_cnt == 2'd0 || (out_take && out_final));
    assign o_rx_stall = r_in_valid && !process;

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_count  = r_count;
        n_held   = r_held;
        n_high   = r_high;
        n_seq    = r_seq;
        n_num    = 2'd0;
        n_bundle = '{default: '0};
        cnt_next = {1'b0, r_count} + 13'd1;
        sent     = {r_high[3:0], 4'b0000} + dpd_pkg::hex_value(r_in_byte);
        case (r_phase)
            dpd_pkg::PH_IDLE: begin
                if (r_in_byte == dpd_pkg::CH_DOLLAR) begin
                    n_sum   = 8'd0;
                    n_count = 12'd0;
                    n_seq   = 1'b0;
                    n_phase = dpd_pkg::PH_PAYLOAD;
                end
            end
            dpd_pkg::PH_PAYLOAD: begin
                if (r_in_byte == dpd_pkg::CH_DOLLAR) begin
                    n_sum       = 8'd0;
                    n_count     = 12'd0;
                    n_seq       = 1'b0;
                    n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_RESTART, 8'd0);
                    n_num       = 2'd1;
                end else if (r_in_byte == dpd_pkg::CH_HASH) begin
                    if (r_count < dpd_pkg::HELD_DEPTH) begin
                        n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_PAYLOAD, r_held[0]);
                        n_bundle[1] = dpd_pkg::simple_result(dpd_pkg::KIND_PAYLOAD, r_held[1]);
                        n_num       = r_count[1:0];
                    end
                    n_phase = dpd_pkg::PH_HIGH;
                end else begin
                    n_sum = r_sum + r_in_byte;
                    if (cnt_next >= {1'b0, r_max}) begin
                        n_phase     = dpd_pkg::PH_IDLE;
                        n_count     = 12'd0;
                        n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_OVERFLOW, 8'd0);
                        n_num       = 2'd1;
                    end else begin
                        if (r_count < dpd_pkg::HELD_DEPTH) begin
                            n_held[r_count[1:0]] = r_in_byte;
                            if (cnt_next[11:0] == dpd_pkg::HELD_DEPTH) begin
                                if (r_in_byte == dpd_pkg::CH_COLON) begin
                                    n_seq = 1'b1;
                                end else begin
                                    n_bundle[0] = dpd_pkg::simple_result(
                                        dpd_pkg::KIND_PAYLOAD, r_held[0]);
                                    n_bundle[1] = dpd_pkg::simple_result(
                                        dpd_pkg::KIND_PAYLOAD, r_held[1]);
                                    n_bundle[2] = dpd_pkg::simple_result(
                                        dpd_pkg::KIND_PAYLOAD, r_in_byte);
                                    n_num       = 2'd3;
                                end
                            end
                        end else begin
                            n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_PAYLOAD,
                                                                 r_in_byte);
                            n_num       = 2'd1;
                        end
                        n_count = cnt_next[11:0];
                    end
                end
            end
            dpd_pkg::PH_HIGH: begin
                n_high  = dpd_pkg::hex_value(r_in_byte);
                n_phase = dpd_pkg::PH_LOW;
            end
            dpd_pkg::PH_LOW: begin
                if (sent == r_sum) begin
                    n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_GOOD, 8'd0);
                    n_bundle[0].ack_char = dpd_pkg::CH_PLUS;
                    if (r_seq) begin
                        n_bundle[0].seq_valid  = 1'b1;
                        n_bundle[0].seq_first  = r_held[0];
                        n_bundle[0].seq_second = r_held[1];
                    end
                end else begin
                    n_bundle[0] = dpd_pkg::simple_result(dpd_pkg::KIND_BAD, 8'd0);
                    n_bundle[0].ack_char = dpd_pkg::CH_MINUS;
                end
                n_num   = 2'd1;
                n_phase = dpd_pkg::PH_IDLE;
            end
            default: begin
                n_phase = dpd_pkg::PH_IDLE;
            end
        endcase
        if (n_num != 2'd0) begin
            n_bundle[n_num - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= dpd_pkg::PH_IDLE;
            r_sum      <= 8'd0;
            r_count    <= 12'd0;
            r_high     <= 8'd0;
            r_seq      <= 1'b0;
            r_max      <= dpd_pkg::MAX_PAYLOAD_RESET;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_idx      <= 2'd0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == dpd_pkg::REG_MAX_PAYLOAD[0]) begin
                r_max <= pwdata[11:0];
            end
            if (i_rx_valid && !o_rx_stall) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_high  <= n_high;
                r_seq   <= n_seq;
                r_cnt   <= n_num;
                r_idx   <= 2'd0;
            end else if (out_take) begin
                if (out_final) begin
                    r_cnt <= 2'd0;
                    r_idx <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (process) begin
            r_held   <= n_held;
            r_bundle <= n_bundle;
        end
    end

    assign cur          = r_bundle[r_idx];
    assign o_res_valid  = r_cnt != 2'd0;
    assign o_kind       = cur.kind;
    assign o_data       = cur.data;
    assign o_ack_char   = cur.ack_char;
    assign o_seq_valid  = cur.seq_valid;
    assign o_seq_first  = cur.seq_first;
    assign o_seq_second = cur.seq_second;
    assign o_last       = cur.last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_idx < r_cnt)
        else $error("result index beyond bundle size");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_last == out_final))
        else $error("last flag does not mark the final result of a byte");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && out_final && !process) |=> !o_res_valid)
        else $error("result still valid after the final one was taken");

    a_payload_no_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == dpd_pkg::KIND_PAYLOAD) |-> (o_ack_char == 8'd0 && !o_seq_valid))
        else $error("payload result carries ack or sequence ID");

endmodule
